FILE: rtl/sle_pkg.sv
// Shared types and constants for the serial line editor.
package sle_pkg;

  localparam int LINE_CAPACITY = 32;
  localparam int STORE_AW      = $clog2(LINE_CAPACITY);
  localparam int FILL_W        = 5;
  localparam int LIMIT_W       = 6;

  localparam logic [FILL_W-1:0]  FILL_MAX    = 5'd31;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;
  localparam logic [LIMIT_W-1:0] LIMIT_MIN   = 6'd2;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX   = LIMIT_W'(LINE_CAPACITY);

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    KIND_ECHO = 2'd0,
    KIND_LINE = 2'd1,
    KIND_END  = 2'd2
  } item_kind_t;

  typedef enum logic [2:0] {
    SEL_NONE,
    SEL_RX,
    SEL_BS,
    SEL_SPACE,
    SEL_RAM
  } out_sel_t;

  // Controller to datapath.
  typedef struct packed {
    logic       latch;
    logic       store_byte;
    logic       fc_dec;
    logic       fc_clr;
    logic       idx_clr;
    logic       idx_inc;
    logic       out_load;
    item_kind_t out_kind;
    out_sel_t   out_sel;
    logic       out_last;
  } sle_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic rx_eol;
    logic rx_bs;
    logic fc_zero;
    logic line_full;
    logic idx_done;
    logic slot_free;
  } sle_status_t;

endpackage

FILE: rtl/sle_if.sv
// Valid/ready channel interfaces for received bytes and result items.
interface sle_in_if import sle_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sle_out_if import sle_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] item_kind;
  logic [7:0] out_byte;
  logic [4:0] line_length;
  logic       last;

  modport source (output valid, output item_kind, output out_byte, output line_length,
                  output last, input ready);
  modport sink   (input valid, input item_kind, input out_byte, input line_length,
                  input last, output ready);
endinterface

FILE: rtl/serial_line_editor.sv
// Top level of the serial line editor: controller plus datapath.
//
// Usage:
//   rx  - valid/ready channel of received bytes (rx_byte), one item per byte.
//   res - valid/ready channel of result items: item_kind (0 echo, 1 line
//         byte, 2 line end), out_byte, line_length (on line end) and last,
//         which marks the final result caused by one received byte.
//   cfg_we/cfg_data - write of line_limit (reset 32, clamped to 2..32); write
//         it only while the block is idle.
// Sequencing:
//   An ordinary byte is accepted and stored while idle; its echo is loaded into
//   the output register from S_ECHO once the slot is free. Backspace: three
//   echo items. A CR/LF: S_RD then S_LB per stored byte (registered store
//   read), then S_END; this also follows the echo of a byte that fills the line.
//   rx.ready is high only while idle; a backspace on an empty line is dropped silently.
// Reset (rst, synchronous): clear the fill count, restore the limit, drop any
//   pending result. The line store is not cleared; only written entries are
//   ever read.
// Stall: a single output register holds the current result while res.ready
//   is low; the controller waits and accepts no new byte until it finishes.
module serial_line_editor import sle_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  sle_in_if.sink             rx,
  sle_out_if.source          res,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_data
);

  sle_cmd_t    cmd;
  sle_status_t st;

  sle_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .rx_valid(rx.valid),
    .rx_ready(rx.ready),
    .st      (st),
    .cmd     (cmd)
  );

  sle_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .rx_byte   (rx.rx_byte),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_kind  (res.item_kind),
    .res_byte  (res.out_byte),
    .res_length(res.line_length),
    .res_last  (res.last)
  );

endmodule

FILE: rtl/sle_ram.sv
// Generic single-port-write, registered-read RAM.
module sle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/sle_ctrl.sv
// Controller state machine: sequences echo, line emission and line end.
module sle_ctrl import sle_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_ready,
  input  sle_status_t st,
  output sle_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ECHO,
    S_BS1,
    S_BS2,
    S_BS3,
    S_RD,
    S_LB,
    S_END
  } state_t;

  state_t state, state_next;
  logic   accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    rx_ready   = (state == S_IDLE);
    accept     = rx_valid && rx_ready;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.latch = 1'b1;
          if (st.rx_eol) begin
            cmd.idx_clr = 1'b1;
            state_next  = S_RD;
          end else if (st.rx_bs) begin
            // backspace on an empty line: drop silently
            if (!st.fc_zero) begin
              cmd.fc_dec = 1'b1;
              state_next = S_BS1;
            end
          end else begin
            cmd.store_byte = 1'b1;
            state_next     = S_ECHO;
          end
        end
      end
      S_ECHO: begin
        if (st.slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_ECHO;
          cmd.out_sel  = SEL_RX;
          cmd.out_last = !st.line_full;
          if (st.line_full) begin
            cmd.idx_clr = 1'b1;
            state_next  = S_RD;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_BS1: begin
        if (st.slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_ECHO;
          cmd.out_sel  = SEL_BS;
          state_next   = S_BS2;
        end
      end
      S_BS2: begin
        if (st.slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_ECHO;
          cmd.out_sel  = SEL_SPACE;
          state_next   = S_BS3;
        end
      end
      S_BS3: begin
        if (st.slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_ECHO;
          cmd.out_sel  = SEL_BS;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_RD: begin
        // RAM address follows the index; the registered read data is ready in S_LB
        state_next = st.idx_done ? S_END : S_LB;
      end
      S_LB: begin
        if (st.slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_LINE;
          cmd.out_sel  = SEL_RAM;
          cmd.idx_inc  = 1'b1;
          state_next   = S_RD;
        end
      end
      S_END: begin
        if (st.slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_END;
          cmd.out_sel  = SEL_NONE;
          cmd.out_last = 1'b1;
          cmd.fc_clr   = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/sle_dp.sv
// Datapath: fill count, line store, read index, limit and output register.
module sle_dp import sle_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         rx_byte,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_data,
  input  sle_cmd_t           cmd,
  output sle_status_t        st,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [1:0]         res_kind,
  output logic [7:0]         res_byte,
  output logic [4:0]         res_length,
  output logic               res_last
);

  logic [LIMIT_W-1:0]  line_limit;
  logic [LIMIT_W-1:0]  lim_eff;
  logic [FILL_W-1:0]   fill_count;
  logic [FILL_W-1:0]   idx;
  logic [7:0]          rx_hold;
  logic [7:0]          ram_rdata;
  logic [7:0]          byte_next;
  logic                store_we;

  assign store_we = cmd.store_byte && (fill_count != FILL_MAX);

  sle_ram #(.WIDTH(8), .DEPTH(LINE_CAPACITY)) u_store (
    .clk  (clk),
    .we   (store_we),
    .waddr(STORE_AW'(fill_count)),
    .wdata(rx_byte),
    .raddr(STORE_AW'(idx)),
    .rdata(ram_rdata)
  );

  always_comb begin
    lim_eff = line_limit;
    if (lim_eff < LIMIT_MIN) begin
      lim_eff = LIMIT_MIN;
    end
    if (lim_eff > LIMIT_MAX) begin
      lim_eff = LIMIT_MAX;
    end
  end

  always_comb begin
    st.rx_eol    = (rx_byte == CH_LF) || (rx_byte == CH_CR);
    st.rx_bs     = (rx_byte == CH_BS) || (rx_byte == CH_DEL);
    st.fc_zero   = (fill_count == '0);
    st.line_full = ({1'b0, fill_count} >= (lim_eff - LIMIT_W'(1)));
    st.idx_done  = (idx == fill_count);
    st.slot_free = !res_valid || res_ready;
  end

  always_comb begin
    case (cmd.out_sel)
      SEL_RX:    byte_next = rx_hold;
      SEL_BS:    byte_next = CH_BS;
      SEL_SPACE: byte_next = CH_SPACE;
      SEL_RAM:   byte_next = ram_rdata;
      default:   byte_next = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit <= LIMIT_RESET;
      fill_count <= '0;
      idx        <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        line_limit <= cfg_data;
      end
      if (cmd.fc_clr) begin
        fill_count <= '0;
      end else if (cmd.fc_dec) begin
        fill_count <= fill_count - FILL_W'(1);
      end else if (store_we) begin
        fill_count <= fill_count + FILL_W'(1);
      end
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + FILL_W'(1);
      end
      if (cmd.out_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      rx_hold <= rx_byte;
    end
    if (cmd.out_load) begin
      res_kind   <= cmd.out_kind;
      res_byte   <= byte_next;
      res_length <= (cmd.out_kind == KIND_END) ? fill_count : 5'd0;
      res_last   <= cmd.out_last;
    end
  end

endmodule

FILE: rtl/sle_checker.sv
// Port-level checks for the serial line editor, bound to the top level.
module sle_props import sle_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       rx_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic [1:0] item_kind,
  input logic [7:0] out_byte,
  input logic [4:0] line_length,
  input logic       last
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(item_kind) && $stable(out_byte)
      && $stable(line_length) && $stable(last))
    else $error("stalled result changed");

  // a line end carries no byte and closes the item's results
  assert property (@(posedge clk) disable iff (rst)
    res_valid && (item_kind == KIND_END) |-> (out_byte == 8'h00) && last)
    else $error("malformed line end");

  // only a line end carries a length
  assert property (@(posedge clk) disable iff (rst)
    res_valid && (item_kind != KIND_END) |-> (line_length == 5'd0))
    else $error("length on non line-end result");

  // no byte is taken while a line is being emitted
  assert property (@(posedge clk) disable iff (rst)
    res_valid && (item_kind == KIND_LINE) |-> !rx_ready && !last)
    else $error("input taken during line emission");

endmodule

bind serial_line_editor sle_props u_sle_checker (
  .clk        (clk),
  .rst        (rst),
  .rx_ready   (rx.ready),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .item_kind  (res.item_kind),
  .out_byte   (res.out_byte),
  .line_length(res.line_length),
  .last       (res.last)
);
